// File: rtl/bgf_pkg.sv
// Package for the battery gauge filter: widths, reset values, control types
// and the elaboration-time builder for the LiPo charge curve.
// No dependencies.
`default_nettype none

package bgf_pkg;

  // default parameter values
  localparam int CURVE_TABLE_DEPTH_DEF = 256;
  localparam int FRACTION_BITS_DEF     = 8;

  // field and port widths
  localparam int WORD_W      = 16;
  localparam int PCT_W       = 7;
  localparam int MV_W        = 15;
  localparam int CUR_W       = 16;
  localparam int WEIGHT_W    = 16;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 40;
  localparam int M_USER_W    = 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // register reset values (0.99 and 0.7 in Q16)
  localparam logic [WEIGHT_W-1:0] VSMOOTH_RST = 16'd64881;
  localparam logic [WEIGHT_W-1:0] CSMOOTH_RST = 16'd45875;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_SMOOTHING = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_SMOOTHING = 1'b1;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam int WEIGHT_ONE = 65536;
  localparam int ROUND_HALF = 32768;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_MUL0,
    ST_V_MUL1,
    ST_V_UPD,
    ST_I_MUL1,
    ST_I_UPD,
    ST_PCT_SETUP,
    ST_DIVIDE,
    ST_OUTPUT
  } bgf_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_v_old;
    logic mul_v_new;
    logic upd_v;
    logic mul_i_old;
    logic mul_i_new;
    logic upd_i;
    logic pct_load;
    logic div_step;
    logic out_load;
  } bgf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic taken;
    logic out_free;
  } bgf_status_t;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // restoring long division, only used while building the curve
  function automatic logic [63:0] bgf_div64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-t in Q30: scale down by 64, short taylor series, square six times
  function automatic logic [63:0] bgf_exp_neg_q30(input logic [63:0] t);
    logic [63:0] z;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] e;
    z  = t >> 6;
    t2 = ((z * z) >> 30) >> 1;
    t3 = bgf_div64((t2 * z) >> 30, 64'd3);
    t4 = ((t3 * z) >> 30) >> 2;
    e  = Q30_ONE + t2 + t4 - z - t3;
    for (int k = 0; k < 6; k++) begin
      e = (e * e + (Q30_ONE >> 1)) >> 30;
    end
    return e;
  endfunction

  // logistic of num/den in Q30
  function automatic logic [63:0] bgf_logistic_q30(input logic signed [63:0] num,
                                                   input logic [63:0] den);
    logic [63:0] mag;
    logic [63:0] e;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    e   = bgf_exp_neg_q30(bgf_div64(mag << 30, den));
    if (num >= 0) begin
      return bgf_div64(Q30_ONE << 30, Q30_ONE + e);
    end
    return bgf_div64(e << 30, Q30_ONE + e);
  endfunction

  // curve entry: logistic at segment midpoint, rescaled to 0..100
  function automatic logic [PCT_W-1:0] bgf_curve_entry(input int idx, input int depth);
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] d;
    logic [63:0] s;
    logic [63:0] p;
    logic signed [63:0] n;
    s0 = bgf_logistic_q30(-64'sd28, 64'd5);
    s1 = bgf_logistic_q30(64'sd12, 64'd5);
    d  = (s1 > s0) ? s1 - s0 : 64'd0;
    n  = 64'sd20 * (2 * 64'(idx) + 64'sd1) - 64'sd28 * 64'(depth);
    s  = bgf_logistic_q30(n, 64'd5 * 64'(depth));
    p  = '0;
    if ((d != 0) && (s > s0)) begin
      p = bgf_div64(64'd200 * (s - s0) + d, 64'd2 * d);
    end
    return (p > 64'd100) ? PCT_FULL : p[PCT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/bgf_ctrl.sv
// Controller of the battery gauge filter: sequences the shared multiplier,
// the average updates, the percent divider and the output load.
// Depends on bgf_pkg.
`default_nettype none

module bgf_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  bgf_pkg::bgf_status_t status_i,
  output bgf_pkg::bgf_cmd_t    cmd_o
);
  import bgf_pkg::*;

  bgf_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_V_MUL0;
      end
      ST_V_MUL0: begin
        state_d = status_i.taken ? ST_V_MUL1 : ST_PCT_SETUP;
      end
      ST_V_MUL1:    state_d = ST_V_UPD;
      ST_V_UPD:     state_d = ST_I_MUL1;
      ST_I_MUL1:    state_d = ST_I_UPD;
      ST_I_UPD:     state_d = ST_PCT_SETUP;
      ST_PCT_SETUP: state_d = ST_DIVIDE;
      ST_DIVIDE:    state_d = ST_OUTPUT;
      ST_OUTPUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_V_MUL0: begin
        cmd_o.mul_v_old = status_i.taken;
      end
      ST_V_MUL1: begin
        cmd_o.mul_v_new = 1'b1;
      end
      ST_V_UPD: begin
        cmd_o.upd_v     = 1'b1;
        cmd_o.mul_i_old = 1'b1;
      end
      ST_I_MUL1: begin
        cmd_o.mul_i_new = 1'b1;
      end
      ST_I_UPD: begin
        cmd_o.upd_i = 1'b1;
      end
      ST_PCT_SETUP: begin
        cmd_o.pct_load = 1'b1;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_OUTPUT: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bgf_datapath.sv
// Datapath of the battery gauge filter: smoothing registers, averages, shared
// multiplier, reciprocal percent divider, curve ROM and output register.
// Depends on bgf_pkg.
`default_nettype none

module bgf_datapath #(
  parameter int CURVE_TABLE_DEPTH = bgf_pkg::CURVE_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS     = bgf_pkg::FRACTION_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  bgf_pkg::bgf_cmd_t                  cmd_i,
  output bgf_pkg::bgf_status_t               status_o,
  input  wire  [bgf_pkg::WORD_W-1:0]         bus_word_i,
  input  wire  [bgf_pkg::WORD_W-1:0]         shunt_word_i,
  input  wire                                cfg_we_i,
  input  wire  [bgf_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire  [bgf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               sample_taken_o,
  output logic [bgf_pkg::PCT_W-1:0]          charge_percent_o,
  output logic [bgf_pkg::MV_W-1:0]           pack_millivolts_o,
  output logic signed [bgf_pkg::CUR_W-1:0]   pack_current_o
);
  import bgf_pkg::*;

  localparam int VW   = MV_W + FRACTION_BITS;
  localparam int CW   = CUR_W + FRACTION_BITS;
  localparam int MBW  = WEIGHT_W + 2;
  localparam int PW   = CW + MBW;
  localparam int SW   = PW + 1;
  localparam int IDXW = $clog2(CURVE_TABLE_DEPTH);
  localparam int QW   = (IDXW > PCT_W) ? IDXW : PCT_W;
  localparam int QXW  = QW + 1;
  localparam longint unsigned SC     = 64'd1 << FRACTION_BITS;
  // linear range: (200x + 6000S) / 12000S reduces to (x + 30S) / 60S
  localparam longint unsigned D_LIN  = 60 * SC;
  localparam longint unsigned D_LIPO = 3600 * SC;

  // quotient by reciprocal: m = floor(2^(N+l)/d) + 1, q = (n*m) >> (N+l)
  localparam int NW     = $clog2(D_LIPO * CURVE_TABLE_DEPTH);
  localparam int K_LIN  = NW + $clog2(D_LIN);
  localparam int K_LIPO = NW + $clog2(D_LIPO);
  localparam int RCW    = NW + 2;
  localparam int PRW    = NW + RCW;
  localparam logic [127:0] R_LIN  = ((128'd1 << K_LIN) / 128'(D_LIN)) + 128'd1;
  localparam logic [127:0] R_LIPO = ((128'd1 << K_LIPO) / 128'(D_LIPO)) + 128'd1;

  localparam logic [VW-1:0] V_9K   = VW'(9000 * SC);
  localparam logic [VW-1:0] V_12K6 = VW'(12600 * SC);
  localparam logic [VW-1:0] V_15K  = VW'(15000 * SC);
  localparam logic [VW-1:0] V_19K  = VW'(19000 * SC);
  localparam logic [VW-1:0] V_25K  = VW'(25000 * SC);

  // curve ROM, built at elaboration
  logic [PCT_W-1:0] curve_rom [CURVE_TABLE_DEPTH];
  for (genvar g = 0; g < CURVE_TABLE_DEPTH; g++) begin : g_curve
    localparam logic [PCT_W-1:0] ENTRY = bgf_curve_entry(g, CURVE_TABLE_DEPTH);
    assign curve_rom[g] = ENTRY;
  end

  // configuration registers
  logic [WEIGHT_W-1:0] vs_q, cs_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= VSMOOTH_RST;
      cs_q <= CSMOOTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VOLTAGE_SMOOTHING: vs_q <= cfg_data_i;
        REG_CURRENT_SMOOTHING: cs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured input words
  logic [WORD_W-1:0]        bus_q;
  logic signed [WORD_W-1:0] shunt_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      bus_q   <= bus_word_i;
      shunt_q <= $signed(shunt_word_i);
    end
  end

  logic              taken;
  logic [MV_W-1:0]   mv;
  logic [VW-1:0]     nv;
  logic signed [CW-1:0] na;
  assign taken = |bus_q[WORD_W-1:3];
  assign mv    = {bus_q[WORD_W-1:3], 2'b00};
  assign nv    = VW'(mv) << FRACTION_BITS;
  assign na    = CW'(shunt_q) <<< FRACTION_BITS;

  // averages and first-sample flag
  logic [VW-1:0]        va_q;
  logic signed [CW-1:0] ca_q;
  logic                 started_q;

  // shared multiplier with registered product
  logic signed [CW-1:0]  mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_q;
  logic signed [SW-1:0]  acc_q;
  logic signed [SW-1:0]  sum;
  logic signed [MBW-1:0] vw_old, vw_new, cw_old, cw_new;

  assign vw_old = $signed({2'b00, vs_q});
  assign vw_new = $signed(MBW'(WEIGHT_ONE) - {2'b00, vs_q});
  assign cw_old = $signed({2'b00, cs_q});
  assign cw_new = $signed(MBW'(WEIGHT_ONE) - {2'b00, cs_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_v_old) begin
      mul_a = $signed({1'b0, va_q});
      mul_b = vw_old;
    end else if (cmd_i.mul_v_new) begin
      mul_a = $signed({1'b0, nv});
      mul_b = vw_new;
    end else if (cmd_i.mul_i_old) begin
      mul_a = ca_q;
      mul_b = cw_old;
    end else if (cmd_i.mul_i_new) begin
      mul_a = na;
      mul_b = cw_new;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.mul_v_new || cmd_i.mul_i_new) begin
      acc_q <= SW'(prod_q);
    end
  end

  // old*w + new*(1-w), rounded, then scaled back by 2^16
  assign sum = acc_q + SW'(prod_q) + SW'(ROUND_HALF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= '0;
      ca_q      <= '0;
      started_q <= 1'b0;
    end else begin
      if (cmd_i.upd_v) begin
        va_q <= (va_q == '0) ? nv : sum[16 +: VW];
      end
      if (cmd_i.upd_i) begin
        ca_q      <= started_q ? $signed(sum[16 +: CW]) : na;
        started_q <= 1'b1;
      end
    end
  end

  // percent setup: range select, clamps and quotient numerator
  logic           lin_q, direct_q, dhi_q;
  logic           lin, direct, dhi;
  logic [VW-1:0]  x_lin, x_lipo;
  logic [NW-1:0]  num, num_q;
  logic [RCW-1:0] recip;
  logic [PRW-1:0] quot_prod;
  logic [QW-1:0]  q_q;

  assign x_lin  = va_q - V_19K;
  assign x_lipo = va_q - V_9K;

  always_comb begin
    lin    = va_q > V_15K;
    direct = 1'b0;
    dhi    = 1'b0;
    if (lin) begin
      if (va_q <= V_19K) begin
        direct = 1'b1;
      end else if (va_q >= V_25K) begin
        direct = 1'b1;
        dhi    = 1'b1;
      end
      num = NW'(x_lin) + NW'(30 * SC);
    end else begin
      if (va_q <= V_9K) begin
        direct = 1'b1;
      end else if (va_q >= V_12K6) begin
        direct = 1'b1;
        dhi    = 1'b1;
      end
      num = NW'(x_lipo) * NW'(CURVE_TABLE_DEPTH);
    end
  end

  // quotient as one multiply by the constant reciprocal of the range divisor
  assign recip     = lin_q ? RCW'(R_LIN) : RCW'(R_LIPO);
  assign quot_prod = PRW'(num_q) * PRW'(recip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pct_load) begin
      lin_q    <= lin;
      direct_q <= direct;
      dhi_q    <= dhi;
      num_q    <= num;
    end
    if (cmd_i.div_step) begin
      q_q <= lin_q ? QW'(quot_prod >> K_LIN) : QW'(quot_prod >> K_LIPO);
    end
  end

  // final percent from quotient or curve
  logic [IDXW-1:0]  idx;
  logic [PCT_W-1:0] pct;
  always_comb begin
    idx = ({1'b0, q_q} >= QXW'(CURVE_TABLE_DEPTH)) ? IDXW'(CURVE_TABLE_DEPTH - 1)
                                                  : q_q[IDXW-1:0];
    if (direct_q) begin
      pct = dhi_q ? PCT_FULL : '0;
    end else if (lin_q) begin
      pct = (q_q > QW'(PCT_FULL)) ? PCT_FULL : q_q[PCT_W-1:0];
    end else begin
      pct = curve_rom[idx];
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      sample_taken_o    <= taken;
      charge_percent_o  <= pct;
      pack_millivolts_o <= va_q[FRACTION_BITS +: MV_W];
      pack_current_o    <= $signed(ca_q[FRACTION_BITS +: CUR_W]);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.taken    = taken;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// File: rtl/battery_gauge_filter.sv
// Battery gauge filter top level: joins the controller and the datapath.
// Depends on bgf_pkg, bgf_ctrl and bgf_datapath.
//
// Usage:
//   s_axis carries one sample per transaction: bus voltage word and shunt word.
//   m_axis returns one result per sample: sample_taken flag in tuser, and
//   charge percent, filtered millivolts and filtered current in tdata.
//   cfg_we_i writes a smoothing weight (index 0 voltage, 1 current) at once.
// Timing:
//   One sample is processed at a time. A taken sample runs the voltage and
//   current average updates, then percent setup, divide and output load; a
//   dropped one skips the updates. The four multiplies share one registered
//   multiplier and the percent quotient comes from one reciprocal multiply.
//   The next sample is accepted in the cycle after the result is loaded into
//   the output register.
// Reset:
//   Averages clear to zero (percent reads 0), weights return to 0.99 and 0.7.
// Stall:
//   While m_axis_tready_i is low the result holds in the output register; a
//   new sample may still be accepted and processed, then waits for the slot.
`default_nettype none

module battery_gauge_filter #(
  parameter int CURVE_TABLE_DEPTH = bgf_pkg::CURVE_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS     = bgf_pkg::FRACTION_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // s_axis_tdata_i: bus_word [15:0], shunt_word [31:16]
  input  wire                             s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire  [bgf_pkg::S_DATA_W-1:0]    s_axis_tdata_i,
  // m_axis_tdata_o: charge_percent [6:0], pack_millivolts [21:7],
  //   pack_current [37:22], zero [39:38]
  output logic                            m_axis_tvalid_o,
  input  wire                             m_axis_tready_i,
  output logic [bgf_pkg::M_DATA_W-1:0]    m_axis_tdata_o,
  // m_axis_tuser_o: sample_taken [0]
  output logic [bgf_pkg::M_USER_W-1:0]    m_axis_tuser_o,
  input  wire                             cfg_we_i,
  input  wire  [bgf_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire  [bgf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bgf_pkg::*;

  bgf_cmd_t    cmd;
  bgf_status_t status;

  logic                    sample_taken;
  logic [PCT_W-1:0]        charge_percent;
  logic [MV_W-1:0]         pack_millivolts;
  logic signed [CUR_W-1:0] pack_current;

  bgf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bgf_datapath #(
    .CURVE_TABLE_DEPTH (CURVE_TABLE_DEPTH),
    .FRACTION_BITS     (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .bus_word_i        (s_axis_tdata_i[WORD_W-1:0]),
    .shunt_word_i      (s_axis_tdata_i[2*WORD_W-1:WORD_W]),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .sample_taken_o    (sample_taken),
    .charge_percent_o  (charge_percent),
    .pack_millivolts_o (pack_millivolts),
    .pack_current_o    (pack_current)
  );

  // pack result fields
  assign m_axis_tdata_o = {2'b00, pack_current, pack_millivolts, charge_percent};
  assign m_axis_tuser_o = sample_taken;

endmodule

`default_nettype wire

// File: rtl/bgf_assert.sv
// Port-level assertions for the battery gauge filter, bound to the top level.
// Depends on bgf_pkg and battery_gauge_filter.
`default_nettype none

module bgf_assert (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid_i,
  input wire                             s_axis_tready_o,
  input wire                             m_axis_tvalid_o,
  input wire                             m_axis_tready_i,
  input wire [bgf_pkg::M_DATA_W-1:0]     m_axis_tdata_o,
  input wire [bgf_pkg::M_USER_W-1:0]     m_axis_tuser_o
);
  import bgf_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second sample taken while one is in flight");

  // percent never exceeds full charge
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[6:0] <= PCT_FULL)
    else $error("charge percent above 100");

  // at or below 9 V the pack reads empty
  a_pct_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[21:7] <= 15'd9000) |->
      m_axis_tdata_o[6:0] == 7'd0)
    else $error("nonzero percent at or below 9 V");

endmodule

bind battery_gauge_filter bgf_assert u_bgf_assert (.*);

`default_nettype wire

// File: dv/battery_gauge_filter_checker.sv
// Checker for the battery gauge filter: watches the sample, result and
// register channels, predicts every result and compares it field by field.
// Depends on bgf_pkg.
`timescale 1ns / 100ps

module battery_gauge_filter_checker #(
  parameter int CURVE_TABLE_DEPTH = bgf_pkg::CURVE_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS     = bgf_pkg::FRACTION_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // s_axis_tdata_i: bus_word [15:0], shunt_word [31:16]
  input  logic                             s_axis_tvalid_i,
  input  logic                             s_axis_tready_i,
  input  logic [bgf_pkg::S_DATA_W-1:0]     s_axis_tdata_i,
  // m_axis_tdata_i: charge_percent [6:0], pack_millivolts [21:7],
  //   pack_current [37:22], zero [39:38]
  input  logic                             m_axis_tvalid_i,
  input  logic                             m_axis_tready_i,
  input  logic [bgf_pkg::M_DATA_W-1:0]     m_axis_tdata_i,
  // m_axis_tuser_i: sample_taken [0]
  input  logic [bgf_pkg::M_USER_W-1:0]     m_axis_tuser_i,
  input  logic                             cfg_we_i,
  input  logic [bgf_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [bgf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int                               pending_o,
  output int                               fail_count_o
);
  import bgf_pkg::*;

  typedef longint unsigned u64_t;

  localparam int   VAVG_W  = MV_W + FRACTION_BITS;
  localparam int   CAVG_W  = CUR_W + FRACTION_BITS;
  localparam int   PAD_W   = M_DATA_W - PCT_W - MV_W - CUR_W;
  localparam u64_t S       = u64_t'(1) << FRACTION_BITS;
  localparam u64_t ONE_Q30 = u64_t'(1) << 30;

  typedef struct packed {
    logic             taken;
    logic [PCT_W-1:0] pct;
    logic [MV_W-1:0]  mv;
    logic [CUR_W-1:0] cur;
  } gauge_reading_t;

  // filter state and smoothing weights as the block holds them
  logic [VAVG_W-1:0]        volt_avg;
  logic signed [CAVG_W-1:0] cur_avg;
  logic                     cur_started;
  logic [WEIGHT_W-1:0]      volt_weight;
  logic [WEIGHT_W-1:0]      cur_weight;

  logic [PCT_W-1:0] soc_curve [CURVE_TABLE_DEPTH];
  gauge_reading_t   expected_readings [$];
  int               fail_count = 0;

  assign fail_count_o = fail_count;

  // e^-t in q30: shrink by 64, taylor series, then square back up six times
  function automatic u64_t decay_q30(input u64_t t);
    u64_t z, t2, t3, t4, e;
    z  = t >> 6;
    t2 = ((z * z) >> 30) / 2;
    t3 = ((t2 * z) >> 30) / 3;
    t4 = ((t3 * z) >> 30) / 4;
    e  = ONE_Q30 + t2 + t4 - z - t3;
    for (int k = 0; k < 6; k++) begin
      e = (e * e + (ONE_Q30 >> 1)) >> 30;
    end
    return e;
  endfunction

  // logistic of num/den in q30
  function automatic u64_t sigmoid_q30(input longint num, input u64_t den);
    u64_t mag, e;
    mag = (num < 0) ? u64_t'(-num) : u64_t'(num);
    e   = decay_q30((mag << 30) / den);
    if (num >= 0) begin
      return (ONE_Q30 << 30) / (ONE_Q30 + e);
    end
    return (e << 30) / (ONE_Q30 + e);
  endfunction

  // lipo curve at the segment midpoint, rescaled to 0..100 and rounded
  function automatic logic [PCT_W-1:0] lipo_curve_point(input int idx);
    u64_t   lo, hi, span, s, p;
    longint n;
    lo   = sigmoid_q30(-28, 5);
    hi   = sigmoid_q30(12, 5);
    span = (hi > lo) ? hi - lo : 0;
    n    = 20 * (2 * longint'(idx) + 1) - 28 * longint'(CURVE_TABLE_DEPTH);
    s    = sigmoid_q30(n, 5 * u64_t'(CURVE_TABLE_DEPTH));
    p    = 0;
    if (span != 0 && s > lo) begin
      p = (200 * (s - lo) + span) / (2 * span);
    end
    return (p > 100) ? PCT_FULL : PCT_W'(p);
  endfunction

  initial begin
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      soc_curve[i] = lipo_curve_point(i);
    end
  end

  // charge percent: linear above 15 V, lipo curve at or below
  function automatic logic [PCT_W-1:0] soc_percent(input logic [VAVG_W-1:0] v);
    u64_t vv, p, idx;
    vv = u64_t'(v);
    if (vv > 15000 * S) begin
      if (vv <= 19000 * S) return '0;
      if (vv >= 25000 * S) return PCT_FULL;
      p = (200 * (vv - 19000 * S) + 6000 * S) / (12000 * S);
      return (p > 100) ? PCT_FULL : PCT_W'(p);
    end
    if (vv <= 9000 * S) return '0;
    if (vv >= 12600 * S) return PCT_FULL;
    idx = (vv - 9000 * S) * CURVE_TABLE_DEPTH / (3600 * S);
    if (idx >= CURVE_TABLE_DEPTH) idx = CURVE_TABLE_DEPTH - 1;
    return soc_curve[idx];
  endfunction

  // one sample in, filter state updated if the sample is taken, one reading out
  function automatic gauge_reading_t predict_reading(input logic [WORD_W-1:0] bus,
                                                     input logic [WORD_W-1:0] shunt);
    u64_t           mv, nv, acc;
    longint         na, sum;
    gauge_reading_t r;
    mv      = u64_t'(bus >> 3) * 4;
    r.taken = 1'b0;
    if (mv != 0) begin
      nv      = mv * S;
      na      = longint'($signed(shunt)) * longint'(S);
      r.taken = 1'b1;
      // first sample loads the average, later ones blend in
      if (volt_avg == '0) begin
        volt_avg = VAVG_W'(nv);
      end else begin
        acc = u64_t'(volt_avg) * u64_t'(volt_weight)
            + nv * (WEIGHT_ONE - u64_t'(volt_weight)) + ROUND_HALF;
        volt_avg = VAVG_W'(acc >> 16);
      end
      if (!cur_started) begin
        cur_avg     = CAVG_W'(na);
        cur_started = 1'b1;
      end else begin
        sum = longint'(cur_avg) * longint'(cur_weight)
            + na * (WEIGHT_ONE - longint'(cur_weight)) + ROUND_HALF;
        cur_avg = CAVG_W'(sum >>> 16);
      end
    end
    r.pct = soc_percent(volt_avg);
    r.mv  = MV_W'(volt_avg >> FRACTION_BITS);
    r.cur = CUR_W'(cur_avg >>> FRACTION_BITS);
    return r;
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endtask

  // register writes, then results against the oldest prediction, then samples
  always @(posedge clk_i or negedge rst_ni) begin
    gauge_reading_t want;
    if (!rst_ni) begin
      volt_avg    = '0;
      cur_avg     = '0;
      cur_started = 1'b0;
      volt_weight = VSMOOTH_RST;
      cur_weight  = CSMOOTH_RST;
      expected_readings.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VOLTAGE_SMOOTHING: volt_weight = cfg_data_i;
          REG_CURRENT_SMOOTHING: cur_weight  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_readings.size() == 0) begin
          $error("result transaction with no sample waiting: tdata %h", m_axis_tdata_i);
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("sample_taken", longint'(want.taken), longint'(m_axis_tuser_i[0]));
          check_field("charge_percent", longint'(want.pct),
                      longint'(m_axis_tdata_i[PCT_W-1:0]));
          check_field("pack_millivolts", longint'(want.mv),
                      longint'(m_axis_tdata_i[PCT_W +: MV_W]));
          check_field("pack_current", longint'($signed(want.cur)),
                      longint'($signed(m_axis_tdata_i[PCT_W+MV_W +: CUR_W])));
          check_field("tdata padding", 0,
                      longint'(m_axis_tdata_i[M_DATA_W-1 -: PAD_W]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_readings.push_back(predict_reading(s_axis_tdata_i[WORD_W-1:0],
                                                    s_axis_tdata_i[2*WORD_W-1:WORD_W]));
      end
      pending_o <= expected_readings.size();
    end
  end

endmodule

// File: dv/battery_gauge_filter_tb.sv
// Testbench top for the battery gauge filter: clock, reset, sample and
// register stimulus, result back-pressure, watchdog and final verdict.
// Depends on bgf_pkg, battery_gauge_filter and battery_gauge_filter_checker.
`timescale 1ns / 100ps

module battery_gauge_filter_tb;
  import bgf_pkg::*;

  localparam int SEG_SAMPLES    = 225;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  logic                   clk_i;
  logic                   rst_n     = 1'b0;
  logic                   s_tvalid  = 1'b0;
  logic [S_DATA_W-1:0]    s_tdata   = '0;
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_VOLTAGE_SMOOTHING;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [M_DATA_W-1:0]    m_axis_tdata_o;
  logic [M_USER_W-1:0]    m_axis_tuser_o;

  int pending;
  int fail_count;
  int send_idle_pct  = 29;
  int recv_stall_pct = 48;
  int stalled_cycles = 0;

  battery_gauge_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  battery_gauge_filter_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // random back-pressure on the result side
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // watchdog: too long without any transaction ends the run
  always @(posedge clk_i) begin
    if (!rst_n || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("battery_gauge_filter test failed");
      $finish;
    end
  end

  // one sample transaction, after a random number of idle cycles
  task automatic feed_sample(input logic [WORD_W-1:0] bus, input logic [WORD_W-1:0] shunt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {shunt, bus};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every predicted result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_smoothing(input logic [WEIGHT_W-1:0] volt_w,
                               input logic [WEIGHT_W-1:0] cur_w);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VOLTAGE_SMOOTHING;
    cfg_data  <= volt_w;
    @(posedge clk_i);
    cfg_index <= REG_CURRENT_SMOOTHING;
    cfg_data  <= cur_w;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // bus word for a voltage in mV, junk in the ignored low bits
  function automatic logic [WORD_W-1:0] bus_for_mv(input int mv);
    return {13'(mv / 4), 3'($urandom_range(0, 7))};
  endfunction

  // voltages weighted toward the curve, the linear range and the thresholds
  function automatic logic [WORD_W-1:0] random_bus();
    int pick;
    int edges [5];
    edges = '{9000, 12600, 15000, 19000, 25000};
    pick  = $urandom_range(0, 99);
    if (pick < 6)  return WORD_W'($urandom_range(0, 7));
    if (pick < 32) return bus_for_mv(4 * $urandom_range(2200, 3200));
    if (pick < 58) return bus_for_mv(4 * $urandom_range(3700, 6300));
    if (pick < 70) return bus_for_mv(edges[$urandom_range(0, 4)] + 4 * $urandom_range(0, 4) - 8);
    return WORD_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [WORD_W-1:0] random_shunt();
    int pick;
    logic [WORD_W-1:0] corners [4];
    corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    pick    = $urandom_range(0, 99);
    if (pick < 10) return corners[$urandom_range(0, 3)];
    if (pick < 40) return WORD_W'($urandom_range(0, 4000) - 2000);
    return WORD_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int mv_points [16];
    logic [WORD_W-1:0] shunt_points [5];
    mv_points    = '{4, 9000, 9004, 10800, 12596, 12600, 14996, 15000,
                     15004, 18996, 19000, 19004, 22000, 24996, 25000, 32764};
    shunt_points = '{16'h8000, 16'h7fff, 16'hffff, 16'h0001, 16'h0000};

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // dropped samples before the first read, then first loads at the extremes
    feed_sample(16'h0000, 16'h0000);
    feed_sample(16'h0007, 16'h8000);
    feed_sample(16'hffff, 16'h7fff);
    feed_sample(16'h0008, 16'h8000);
    feed_sample(16'h5555, 16'haaaa);
    drain_results();

    // no smoothing: every percent threshold on its own sample
    set_smoothing('0, '0);
    foreach (mv_points[i]) begin
      feed_sample(bus_for_mv(mv_points[i]), shunt_points[i % 5]);
    end
    // dropped sample once the filter holds a value
    feed_sample(16'h0005, 16'h1234);
    drain_results();

    // random segments, each with its own weights; each pair shares an idling mix
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct  = 29;
          recv_stall_pct = 48;
        end
        1: begin
          send_idle_pct  = 48;
          recv_stall_pct = 29;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (seg)
        0: set_smoothing(VSMOOTH_RST, CSMOOTH_RST);
        1: set_smoothing(16'hffff, 16'hffff);
        3: set_smoothing(16'h0000, 16'hffff);
        4: set_smoothing(16'hffff, 16'h0000);
        default: set_smoothing(WEIGHT_W'($urandom_range(0, 65535)),
                               WEIGHT_W'($urandom_range(0, 65535)));
      endcase
      repeat (SEG_SAMPLES) feed_sample(random_bus(), random_shunt());
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("battery_gauge_filter test passed");
    end else begin
      $display("battery_gauge_filter test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bgf_pkg.sv
rtl/bgf_ctrl.sv
rtl/bgf_datapath.sv
rtl/battery_gauge_filter.sv
rtl/bgf_assert.sv
dv/battery_gauge_filter_checker.sv
dv/battery_gauge_filter_tb.sv
